/* rtl/core/cwa_pkg.sv */
// ----------------------------------------------------------------------------
// cwa_pkg
// shared codes, constants and types of the clock with alarm and digit entry
// ----------------------------------------------------------------------------
`default_nettype none

package cwa_pkg;

	localparam logic [1:0] MODE_SEC_TICK  = 2'd0;
	localparam logic [1:0] MODE_BUZZ_TICK = 2'd1;
	localparam logic [1:0] MODE_KEY       = 2'd2;

	localparam logic [1:0] EDIT_NONE  = 2'd0;
	localparam logic [1:0] EDIT_CLOCK = 2'd1;
	localparam logic [1:0] EDIT_ALARM = 2'd2;

	localparam logic [1:0] STATUS_OFF     = 2'd0;
	localparam logic [1:0] STATUS_ARMED   = 2'd1;
	localparam logic [1:0] STATUS_RINGING = 2'd2;

	localparam logic [7:0] KEY_ALARM_SET = 8'h2B;
	localparam logic [7:0] KEY_ALARM_OFF = 8'h2E;
	localparam logic [7:0] KEY_ZERO      = 8'h30;
	localparam logic [7:0] KEY_NINE      = 8'h39;

	localparam logic [1:0] REG_BUZZ_ON     = 2'd0;
	localparam logic [1:0] REG_BUZZ_PERIOD = 2'd1;

	localparam logic [7:0] BUZZ_ON_RESET     = 8'd30;
	localparam logic [7:0] BUZZ_PERIOD_RESET = 8'd45;

	localparam logic [5:0] SIXTY      = 6'd60;
	localparam logic [4:0] TWENTY_FOUR = 5'd24;
	localparam logic [4:0] TWENTY     = 5'd20;
	localparam logic [2:0] LAST_DIGIT = 3'd5;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} cwa_digit_t;

	typedef struct packed {
		logic [4:0] time_hours;
		logic [5:0] time_minutes;
		logic [5:0] time_seconds;
		logic [4:0] wake_hours;
		logic [5:0] wake_minutes;
		logic [5:0] wake_seconds;
		logic       buzzer_drive;
		logic [1:0] alarm_status;
		logic [1:0] edit_target;
		logic [2:0] digit_position;
	} cwa_view_t;

endpackage

`default_nettype wire

/* rtl/core/clock_with_alarm_and_digit_entry.sv */
// ----------------------------------------------------------------------------
// clock_with_alarm_and_digit_entry
// 24-hour clock with alarm, buzzer pulsing and six-digit time entry
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry mode and key_code; a request is
// taken on a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry one result per request, the
// clock, alarm, buzzer, status and entry state after that request.
// path: input register, then the result register, which raises out_valid and
// holds the result until it is taken.
// throughput: one request per cycle unless stalled; state update is one short
// combinational pass between the input register and the state/result registers.
// stall: while the result waits under out_stall, one more request is held in
// the input register; in_stall rises only when both registers are full.
// reset: clock and alarm at 00:00:00, buzzer off, status off, clock entry
// pending at digit 0; buzz_on_ticks is 30 and buzz_period_ticks is 45.
// configuration: cfg_we with cfg_index 0 or 1 writes cfg_wdata into one of the
// two buzzer registers; other indexes are ignored. write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_with_alarm_and_digit_entry (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [7:0] key_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [4:0]      time_hours,
	output logic [5:0]      time_minutes,
	output logic [5:0]      time_seconds,
	output logic [4:0]      wake_hours,
	output logic [5:0]      wake_minutes,
	output logic [5:0]      wake_seconds,
	output logic            buzzer_drive,
	output logic [1:0]      alarm_status,
	output logic [1:0]      edit_target,
	output logic [2:0]      digit_position
);
	import cwa_pkg::*;

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] key_s1;
	logic       out_valid_q;
	cwa_view_t  result_q;
	cwa_view_t  nxt;
	logic       advance;

	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			key_s1  <= key_code;
		end
	end

	cwa_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.mode      (mode_s1),
		.key_code  (key_s1),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign time_hours     = result_q.time_hours;
	assign time_minutes   = result_q.time_minutes;
	assign time_seconds   = result_q.time_seconds;
	assign wake_hours     = result_q.wake_hours;
	assign wake_minutes   = result_q.wake_minutes;
	assign wake_seconds   = result_q.wake_seconds;
	assign buzzer_drive   = result_q.buzzer_drive;
	assign alarm_status   = result_q.alarm_status;
	assign edit_target    = result_q.edit_target;
	assign digit_position = result_q.digit_position;

endmodule

`default_nettype wire

/* rtl/core/cwa_digit.sv */
// ----------------------------------------------------------------------------
// cwa_digit
// checks one entry key against the digit expected at the current position
// ----------------------------------------------------------------------------
`default_nettype none

module cwa_digit (
	input  wire logic [7:0]          key_code,
	input  wire logic [2:0]          position,
	input  wire logic [4:0]          hours,
	output cwa_pkg::cwa_digit_t      digit
);
	import cwa_pkg::*;

	logic       is_digit;
	logic [3:0] d;
	logic       fits;

	assign is_digit = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
	assign d        = key_code[3:0];

	always_comb begin
		unique case (position)
			3'd0:       fits = (d <= 4'd2);
			3'd1:       fits = ((hours == TWENTY) && (d <= 4'd3)) || (hours < TWENTY);
			3'd2, 3'd4: fits = (d <= 4'd5);
			3'd3, 3'd5: fits = 1'b1;
			default:    fits = 1'b0;
		endcase
	end

	assign digit.ok    = is_digit && fits;
	assign digit.value = d;

endmodule

`default_nettype wire

/* rtl/core/cwa_state.sv */
// ----------------------------------------------------------------------------
// cwa_state
// clock, alarm, buzzer and entry state with its per-request update
// ----------------------------------------------------------------------------
`default_nettype none

module cwa_state (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                step,
	input  wire logic [1:0]          mode,
	input  wire logic [7:0]          key_code,
	output cwa_pkg::cwa_view_t       nxt
);
	import cwa_pkg::*;

	logic [7:0] buzz_on_q, buzz_period_q;
	logic [4:0] clk_h_q, alm_h_q;
	logic [5:0] clk_m_q, clk_s_q, alm_m_q, alm_s_q;
	logic       ringing_q, buzzer_q;
	logic [7:0] count_q;
	logic [1:0] edit_q, status_q;
	logic [2:0] index_q;

	logic [4:0] clk_h_n, alm_h_n;
	logic [5:0] clk_m_n, clk_s_n, alm_m_n, alm_s_n;
	logic       ringing_n, buzzer_n;
	logic [7:0] count_n;
	logic [1:0] edit_n, status_n;
	logic [2:0] index_n;

	logic [4:0]  tgt_h;
	logic [4:0]  new_h;
	logic [5:0]  tgt_m, tgt_s, new_m, new_s;
	cwa_digit_t  digit;

	assign tgt_h = (edit_q == EDIT_CLOCK) ? clk_h_q : alm_h_q;
	assign tgt_m = (edit_q == EDIT_CLOCK) ? clk_m_q : alm_m_q;
	assign tgt_s = (edit_q == EDIT_CLOCK) ? clk_s_q : alm_s_q;

	cwa_digit u_digit (
		.key_code (key_code),
		.position (index_q),
		.hours    (tgt_h),
		.digit    (digit)
	);

	always_comb begin
		clk_h_n   = clk_h_q;
		clk_m_n   = clk_m_q;
		clk_s_n   = clk_s_q;
		alm_h_n   = alm_h_q;
		alm_m_n   = alm_m_q;
		alm_s_n   = alm_s_q;
		ringing_n = ringing_q;
		buzzer_n  = buzzer_q;
		count_n   = count_q;
		edit_n    = edit_q;
		status_n  = status_q;
		index_n   = index_q;
		new_h     = tgt_h;
		new_m     = tgt_m;
		new_s     = tgt_s;

		if (mode == MODE_SEC_TICK) begin
			if (edit_q != EDIT_CLOCK) begin
				clk_s_n = clk_s_q + 6'd1;
				if (clk_s_n >= SIXTY) begin
					clk_s_n = '0;
					clk_m_n = clk_m_q + 6'd1;
				end
				if (clk_m_n >= SIXTY) begin
					clk_m_n = '0;
					clk_h_n = clk_h_q + 5'd1;
				end
				if (clk_h_n >= TWENTY_FOUR) begin
					clk_h_n = '0;
				end
			end
		end else if (mode == MODE_BUZZ_TICK) begin
			if (ringing_q) begin
				count_n = count_q + 8'd1;
			end
		end else if (mode == MODE_KEY) begin
			if (edit_q != EDIT_NONE) begin
				if (digit.ok) begin
					unique case (index_q)
						3'd0:    new_h = tgt_h + 5'(digit.value) * 5'd10;
						3'd1:    new_h = tgt_h + 5'(digit.value);
						3'd2:    new_m = tgt_m + 6'(digit.value) * 6'd10;
						3'd3:    new_m = tgt_m + 6'(digit.value);
						3'd4:    new_s = tgt_s + 6'(digit.value) * 6'd10;
						default: new_s = tgt_s + 6'(digit.value);
					endcase
					if (edit_q == EDIT_CLOCK) begin
						clk_h_n = new_h;
						clk_m_n = new_m;
						clk_s_n = new_s;
					end else begin
						alm_h_n = new_h;
						alm_m_n = new_m;
						alm_s_n = new_s;
					end
					if (index_q == LAST_DIGIT) begin
						if (edit_q == EDIT_ALARM) begin
							status_n = STATUS_ARMED;
						end
						edit_n  = EDIT_NONE;
						index_n = '0;
					end else begin
						index_n = index_q + 3'd1;
					end
				end
			end else if (key_code == KEY_ALARM_SET) begin
				alm_h_n = '0;
				alm_m_n = '0;
				alm_s_n = '0;
				edit_n  = EDIT_ALARM;
				index_n = '0;
			end else if (key_code == KEY_ALARM_OFF) begin
				buzzer_n  = 1'b0;
				ringing_n = 1'b0;
				alm_h_n   = '0;
				alm_m_n   = '0;
				alm_s_n   = '0;
				status_n  = STATUS_OFF;
			end
		end

		if (edit_n == EDIT_NONE) begin
			if ((alm_h_n == clk_h_n) && (alm_m_n == clk_m_n) && (alm_s_n == clk_s_n)) begin
				ringing_n = 1'b1;
				buzzer_n  = 1'b1;
				status_n  = STATUS_RINGING;
			end
			if (ringing_n) begin
				if (count_n >= buzz_on_q) begin
					buzzer_n = 1'b0;
				end
				if (count_n >= buzz_period_q) begin
					buzzer_n = 1'b1;
					count_n  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buzz_on_q     <= BUZZ_ON_RESET;
			buzz_period_q <= BUZZ_PERIOD_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BUZZ_ON) begin
				buzz_on_q <= cfg_wdata;
			end
			if (cfg_index == REG_BUZZ_PERIOD) begin
				buzz_period_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_h_q   <= '0;
			clk_m_q   <= '0;
			clk_s_q   <= '0;
			alm_h_q   <= '0;
			alm_m_q   <= '0;
			alm_s_q   <= '0;
			ringing_q <= 1'b0;
			buzzer_q  <= 1'b0;
			count_q   <= '0;
			edit_q    <= EDIT_CLOCK;
			index_q   <= '0;
			status_q  <= STATUS_OFF;
		end else if (step) begin
			clk_h_q   <= clk_h_n;
			clk_m_q   <= clk_m_n;
			clk_s_q   <= clk_s_n;
			alm_h_q   <= alm_h_n;
			alm_m_q   <= alm_m_n;
			alm_s_q   <= alm_s_n;
			ringing_q <= ringing_n;
			buzzer_q  <= buzzer_n;
			count_q   <= count_n;
			edit_q    <= edit_n;
			index_q   <= index_n;
			status_q  <= status_n;
		end
	end

	assign nxt.time_hours     = clk_h_n;
	assign nxt.time_minutes   = clk_m_n;
	assign nxt.time_seconds   = clk_s_n;
	assign nxt.wake_hours     = alm_h_n;
	assign nxt.wake_minutes   = alm_m_n;
	assign nxt.wake_seconds   = alm_s_n;
	assign nxt.buzzer_drive   = buzzer_n;
	assign nxt.alarm_status   = status_n;
	assign nxt.edit_target    = edit_n;
	assign nxt.digit_position = index_n;

	a_buzz_needs_ring: assert property (@(posedge clk) disable iff (!arst_n)
		buzzer_q |-> ringing_q)
		else $error("buzzer on without ringing");

	a_index_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(edit_q == EDIT_NONE) |-> (index_q == 3'd0))
		else $error("digit position not cleared outside entry");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= LAST_DIGIT)
		else $error("digit position out of range");

	a_clock_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (edit_q == EDIT_CLOCK) && (mode == MODE_SEC_TICK)) |=> $stable(clk_s_q))
		else $error("clock advanced during clock entry");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(clk_s_q < SIXTY) && (clk_m_q < SIXTY) && (clk_h_q < TWENTY_FOUR))
		else $error("clock time out of range");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the clock with alarm and digit entry: a queue-fed
// driver offers second ticks, buzzer ticks and key presses with random gaps,
// a monitor stalls the result channel at random and compares every result
// field by field with an in-bench predictor of the clock, alarm and buzzer.
// stimulus runs in phases, each under its own buzzer register setting.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import cwa_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;
	localparam int DAY_SECONDS = 86400;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 175;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] key;
	} key_request_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_wdata = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] mode = MODE_SEC_TICK;
	logic [7:0] key_code = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] time_hours;
	logic [5:0] time_minutes;
	logic [5:0] time_seconds;
	logic [4:0] wake_hours;
	logic [5:0] wake_minutes;
	logic [5:0] wake_seconds;
	logic       buzzer_drive;
	logic [1:0] alarm_status;
	logic [1:0] edit_target;
	logic [2:0] digit_position;

	// predicted state of the watch
	logic [4:0] clk_h = 5'd0;
	logic [5:0] clk_m = 6'd0;
	logic [5:0] clk_s = 6'd0;
	logic [4:0] alm_h = 5'd0;
	logic [5:0] alm_m = 6'd0;
	logic [5:0] alm_s = 6'd0;
	logic       ring_on = 1'b0;
	logic       buzz_lvl = 1'b0;
	logic [7:0] buzz_cnt = 8'd0;
	logic [1:0] edit_mode = EDIT_CLOCK;
	logic [2:0] digit_idx = 3'd0;
	logic [1:0] status_lvl = STATUS_OFF;
	logic [7:0] on_ticks = BUZZ_ON_RESET;
	logic [7:0] period_ticks = BUZZ_PERIOD_RESET;

	key_request_t key_requests[$];
	cwa_view_t    watch_views[$];
	key_request_t next_request;
	cwa_view_t    got_view;
	cwa_view_t    want_view;

	int  errors = 0;
	int  queued = 0;
	int  requests_sent = 0;
	int  results_seen = 0;
	int  rings_started = 0;
	int  plan_secs = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	logic quiet = 1'b0;
	logic took_result;

	clock_with_alarm_and_digit_entry dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.time_hours(time_hours),
		.time_minutes(time_minutes),
		.time_seconds(time_seconds),
		.wake_hours(wake_hours),
		.wake_minutes(wake_minutes),
		.wake_seconds(wake_seconds),
		.buzzer_drive(buzzer_drive),
		.alarm_status(alarm_status),
		.edit_target(edit_target),
		.digit_position(digit_position)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic cwa_view_t step_watch(logic [1:0] m, logic [7:0] k);
		cwa_view_t  v;
		logic [3:0] d;
		logic [4:0] th;
		logic [5:0] tm;
		logic [5:0] ts;
		logic       ok;
		if (m == MODE_SEC_TICK) begin
			if (edit_mode != EDIT_CLOCK) begin
				clk_s = clk_s + 6'd1;
				if (clk_s >= SIXTY) begin
					clk_s = 6'd0;
					clk_m = clk_m + 6'd1;
				end
				if (clk_m >= SIXTY) begin
					clk_m = 6'd0;
					clk_h = clk_h + 5'd1;
				end
				if (clk_h >= TWENTY_FOUR)
					clk_h = 5'd0;
			end
		end else if (m == MODE_BUZZ_TICK) begin
			if (ring_on)
				buzz_cnt = buzz_cnt + 8'd1;
		end else if (m == MODE_KEY) begin
			if (edit_mode != EDIT_NONE) begin
				if (k >= KEY_ZERO && k <= KEY_NINE) begin
					d = 4'(k - KEY_ZERO);
					th = (edit_mode == EDIT_CLOCK) ? clk_h : alm_h;
					tm = (edit_mode == EDIT_CLOCK) ? clk_m : alm_m;
					ts = (edit_mode == EDIT_CLOCK) ? clk_s : alm_s;
					ok = 1'b0;
					case (digit_idx)
						3'd0: if (d <= 4'd2) begin
							th = th + 5'd10 * d;
							ok = 1'b1;
						end
						3'd1: if ((th == TWENTY && d <= 4'd3) || th < TWENTY) begin
							th = th + d;
							ok = 1'b1;
						end
						3'd2: if (d <= 4'd5) begin
							tm = tm + 6'd10 * d;
							ok = 1'b1;
						end
						3'd3: begin
							tm = tm + d;
							ok = 1'b1;
						end
						3'd4: if (d <= 4'd5) begin
							ts = ts + 6'd10 * d;
							ok = 1'b1;
						end
						3'd5: begin
							ts = ts + d;
							ok = 1'b1;
						end
						default: ok = 1'b0;
					endcase
					if (edit_mode == EDIT_CLOCK) begin
						clk_h = th;
						clk_m = tm;
						clk_s = ts;
					end else begin
						alm_h = th;
						alm_m = tm;
						alm_s = ts;
					end
					if (ok) begin
						if (digit_idx == LAST_DIGIT) begin
							if (edit_mode == EDIT_ALARM)
								status_lvl = STATUS_ARMED;
							edit_mode = EDIT_NONE;
							digit_idx = 3'd0;
						end else begin
							digit_idx = digit_idx + 3'd1;
						end
					end
				end
			end else if (k == KEY_ALARM_SET) begin
				alm_h = 5'd0;
				alm_m = 6'd0;
				alm_s = 6'd0;
				edit_mode = EDIT_ALARM;
				digit_idx = 3'd0;
			end else if (k == KEY_ALARM_OFF) begin
				buzz_lvl = 1'b0;
				ring_on = 1'b0;
				alm_h = 5'd0;
				alm_m = 6'd0;
				alm_s = 6'd0;
				status_lvl = STATUS_OFF;
			end
		end
		if (edit_mode == EDIT_NONE) begin
			if (alm_h == clk_h && alm_m == clk_m && alm_s == clk_s) begin
				if (!ring_on)
					rings_started++;
				ring_on = 1'b1;
				buzz_lvl = 1'b1;
				status_lvl = STATUS_RINGING;
			end
			if (ring_on) begin
				if (buzz_cnt >= on_ticks)
					buzz_lvl = 1'b0;
				if (buzz_cnt >= period_ticks) begin
					buzz_lvl = 1'b1;
					buzz_cnt = 8'd0;
				end
			end
		end
		v.time_hours = clk_h;
		v.time_minutes = clk_m;
		v.time_seconds = clk_s;
		v.wake_hours = alm_h;
		v.wake_minutes = alm_m;
		v.wake_seconds = alm_s;
		v.buzzer_drive = buzz_lvl;
		v.alarm_status = status_lvl;
		v.edit_target = edit_mode;
		v.digit_position = digit_idx;
		return v;
	endfunction

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic void push_item(logic [1:0] m, logic [7:0] k);
		key_request_t req;
		req.mode = m;
		req.key = k;
		key_requests.push_back(req);
		queued++;
		if (m == MODE_SEC_TICK)
			plan_secs = (plan_secs + 1) % DAY_SECONDS;
	endfunction

	// any key but the one that would open alarm entry
	function automatic logic [7:0] stray_key();
		logic [7:0] k;
		do
			k = 8'($urandom_range(0, 255));
		while (k == KEY_ALARM_SET);
		return k;
	endfunction

	// alarm entry of the given time, with ticks and ignored keys mixed in
	function automatic void queue_alarm_entry(int target, int ticks_inside);
		int dig[6];
		int j;
		int r;
		int left;
		logic [7:0] bad;
		dig[0] = target / 36000;
		dig[1] = (target / 3600) % 10;
		dig[2] = (target / 600) % 6;
		dig[3] = (target / 60) % 10;
		dig[4] = (target % 60) / 10;
		dig[5] = target % 10;
		left = ticks_inside;
		push_item(MODE_KEY, KEY_ALARM_SET);
		for (j = 0; j < 6; j++) begin
			while ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 3);
				if (r == 0 && left > 0) begin
					push_item(MODE_SEC_TICK, 8'($urandom_range(0, 255)));
					left--;
				end else if (r <= 1) begin
					push_item(MODE_BUZZ_TICK, 8'($urandom_range(0, 255)));
				end else if (r == 2 && j == 0) begin
					push_item(MODE_KEY, KEY_ZERO + 8'($urandom_range(3, 9)));
				end else if (r == 2 && j == 1 && dig[0] == 2) begin
					push_item(MODE_KEY, KEY_ZERO + 8'($urandom_range(4, 9)));
				end else if (r == 2 && (j == 2 || j == 4)) begin
					push_item(MODE_KEY, KEY_ZERO + 8'($urandom_range(6, 9)));
				end else begin
					do
						bad = 8'($urandom_range(0, 255));
					while (bad >= KEY_ZERO && bad <= KEY_NINE);
					push_item(MODE_KEY, bad);
				end
			end
			push_item(MODE_KEY, KEY_ZERO + 8'(dig[j]));
		end
		while (left > 0) begin
			push_item(MODE_SEC_TICK, 8'($urandom_range(0, 255)));
			left--;
		end
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BUZZ_ON)
			on_ticks = val;
		else if (idx == REG_BUZZ_PERIOD)
			period_ticks = val;
		@(negedge clk);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			if (errors < MAX_PRINTED)
				$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_SEC_TICK;
			key_code <= 8'd0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				watch_views.push_back(step_watch(mode, key_code));
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (key_requests.size() != 0) begin
					next_request = key_requests.pop_front();
					in_valid <= 1'b1;
					mode <= next_request.mode;
					key_code <= next_request.key;
					gap_left <= idle_cycles();
					requests_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			took_result = out_valid && !out_stall;
			if (took_result) begin
				got_view = '{time_hours, time_minutes, time_seconds, wake_hours, wake_minutes,
					wake_seconds, buzzer_drive, alarm_status, edit_target, digit_position};
				if (watch_views.size() == 0) begin
					$display("%0t unexpected result: expected none, got %h", $time, got_view);
					errors++;
				end else begin
					want_view = watch_views.pop_front();
					check_field("time_hours", want_view.time_hours, got_view.time_hours);
					check_field("time_minutes", want_view.time_minutes, got_view.time_minutes);
					check_field("time_seconds", want_view.time_seconds, got_view.time_seconds);
					check_field("wake_hours", want_view.wake_hours, got_view.wake_hours);
					check_field("wake_minutes", want_view.wake_minutes, got_view.wake_minutes);
					check_field("wake_seconds", want_view.wake_seconds, got_view.wake_seconds);
					check_field("buzzer_drive", want_view.buzzer_drive, got_view.buzzer_drive);
					check_field("alarm_status", want_view.alarm_status, got_view.alarm_status);
					check_field("edit_target", want_view.edit_target, got_view.edit_target);
					check_field("digit_position", want_view.digit_position,
						got_view.digit_position);
				end
				results_seen <= results_seen + 1;
			end
			// long hold-offs let the block fill up and stall its input
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (took_result && (results_seen == 400 || results_seen == 1000)) begin
				hold_left <= 120;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= idle_cycles();
			end
		end
	end

	initial begin : stimulus
		int p;
		int r;
		int lead;
		int entry_ticks;
		int span;
		int phase_end;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first clock entry: ignored items, rejected digits, then 23:59:58
		push_item(MODE_SEC_TICK, 8'hFF);
		push_item(MODE_BUZZ_TICK, 8'h00);
		push_item(MODE_UNUSED, 8'hFF);
		push_item(MODE_KEY, KEY_ALARM_SET);
		push_item(MODE_KEY, KEY_ALARM_OFF);
		push_item(MODE_KEY, KEY_ZERO + 8'd3);
		push_item(MODE_KEY, KEY_ZERO + 8'd2);
		push_item(MODE_KEY, KEY_ZERO + 8'd4);
		push_item(MODE_KEY, KEY_ZERO + 8'd3);
		push_item(MODE_KEY, KEY_ZERO + 8'd6);
		push_item(MODE_KEY, KEY_ZERO + 8'd5);
		push_item(MODE_KEY, KEY_NINE);
		push_item(MODE_KEY, KEY_ZERO + 8'd5);
		push_item(MODE_KEY, KEY_ZERO + 8'd8);
		// midnight carry meets the zeroed alarm and rings
		push_item(MODE_SEC_TICK, 8'h00);
		push_item(MODE_SEC_TICK, 8'h00);
		push_item(MODE_BUZZ_TICK, 8'hFF);
		push_item(MODE_KEY, 8'hFF);
		push_item(MODE_KEY, KEY_ALARM_OFF);
		push_item(MODE_KEY, KEY_ALARM_SET);
		push_item(MODE_KEY, KEY_ZERO);
		push_item(MODE_KEY, KEY_ZERO);
		push_item(MODE_KEY, KEY_ZERO);
		push_item(MODE_KEY, KEY_ZERO);
		push_item(MODE_KEY, KEY_ZERO);
		push_item(MODE_KEY, KEY_ZERO + 8'd2);

		for (p = 0; p < PHASES; p++) begin
			while (key_requests.size() != 0 || in_valid || watch_views.size() != 0)
				@(negedge clk);
			repeat (3) @(negedge clk);
			case (p)
				0: begin
					write_reg(REG_BUZZ_ON, 8'd1);
					write_reg(REG_BUZZ_PERIOD, 8'd1);
					write_reg(REG_SPARE_2, 8'hFF);
				end
				1: begin
					write_reg(REG_BUZZ_ON, 8'd255);
					write_reg(REG_BUZZ_PERIOD, 8'd255);
				end
				2: begin
					write_reg(REG_BUZZ_ON, 8'd3);
					write_reg(REG_BUZZ_PERIOD, 8'd7);
				end
				3: begin
					write_reg(REG_BUZZ_ON, 8'd9);
					write_reg(REG_BUZZ_PERIOD, 8'd4);
				end
				4: begin
					write_reg(REG_BUZZ_ON, 8'd1);
					write_reg(REG_BUZZ_PERIOD, 8'd255);
				end
				5: begin
					write_reg(REG_BUZZ_ON, 8'd255);
					write_reg(REG_BUZZ_PERIOD, 8'd1);
					write_reg(REG_SPARE_3, 8'h00);
				end
				6: begin
					write_reg(REG_BUZZ_ON, 8'($urandom_range(1, 255)));
					write_reg(REG_BUZZ_PERIOD, 8'($urandom_range(1, 255)));
				end
				default: begin
					write_reg(REG_BUZZ_ON, BUZZ_ON_RESET);
					write_reg(REG_BUZZ_PERIOD, BUZZ_PERIOD_RESET);
				end
			endcase
			quiet = (p == 2 || p == 5);
			plan_secs = clk_h * 3600 + clk_m * 60 + clk_s;
			phase_end = queued + PHASE_REQUESTS;
			while (queued < phase_end) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					// alarm set a few seconds ahead, run into it, let it ring
					lead = $urandom_range(1, 12);
					entry_ticks = $urandom_range(0, 2);
					queue_alarm_entry((plan_secs + entry_ticks + lead) % DAY_SECONDS,
						entry_ticks);
					repeat (lead + $urandom_range(0, 4)) begin
						repeat ($urandom_range(0, 2))
							push_item(MODE_BUZZ_TICK, 8'($urandom_range(0, 255)));
						push_item(MODE_SEC_TICK, 8'($urandom_range(0, 255)));
					end
					span = period_ticks * 2 + 4;
					if (span > 80)
						span = 80;
					repeat ($urandom_range(0, span)) begin
						r = $urandom_range(0, 15);
						if (r == 0)
							push_item(MODE_SEC_TICK, 8'($urandom_range(0, 255)));
						else if (r == 1)
							push_item(MODE_KEY, stray_key());
						else
							push_item(MODE_BUZZ_TICK, 8'($urandom_range(0, 255)));
					end
					if ($urandom_range(0, 9) < 7)
						push_item(MODE_KEY, KEY_ALARM_OFF);
				end else if (r == 6) begin
					queue_alarm_entry($urandom_range(0, DAY_SECONDS - 1), $urandom_range(0, 3));
				end else if (r == 7) begin
					repeat ($urandom_range(4, 12)) begin
						lead = $urandom_range(0, 3);
						if (lead == MODE_KEY)
							push_item(MODE_KEY, stray_key());
						else
							push_item(2'(lead), 8'($urandom_range(0, 255)));
					end
				end else begin
					repeat ($urandom_range(10, 40)) begin
						if ($urandom_range(0, 7) == 0)
							push_item(MODE_SEC_TICK, 8'($urandom_range(0, 255)));
						else
							push_item(MODE_BUZZ_TICK, 8'($urandom_range(0, 255)));
					end
				end
			end
		end

		while (key_requests.size() != 0 || in_valid || watch_views.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (watch_views.size() != 0)
			errors++;
		$display("checked %0d results for %0d requests over %0d buzzer settings",
			results_seen, requests_sent, PHASES + 1);
		$display("alarm started ringing %0d times; clock entry, alarm entry and stalls exercised",
			rings_started);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
